### rtl/rdsa_pkg.sv
// shared types and constants for the range driven row shift align unit
package rdsa_pkg;

    // row storage: one bank ram per row buffer
    localparam int ROW_LEN = 2048;
    localparam int COL_W   = $clog2(ROW_LEN);
    localparam int LEN_W   = $clog2(ROW_LEN + 1);

    // field widths
    localparam int RANGE_W = 16;
    localparam int SRC_W   = 8;
    localparam int CFG_W   = 32;
    localparam int RLEN_W  = 12;
    localparam int PROD_W  = RANGE_W + 1 + CFG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int RND_W   = SUM_W - FRAC_W + 1;
    localparam int Y_W     = RND_W + 1;

    // output queue and the credit count that guards it
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT_SCALE  = 3'd0,
        REG_SHIFT_OFFSET = 3'd1,
        REG_ROW_LENGTH   = 3'd2,
        REG_WRITE_RANGE  = 3'd3,
        REG_WRITE_SOURCE = 3'd4
    } cfg_reg_t;

    localparam logic signed [CFG_W-1:0] SCALE_RST  = 32'sd65536;
    localparam logic signed [CFG_W-1:0] OFFSET_RST = 32'sd0;
    localparam logic [RLEN_W-1:0]       RLEN_RST   = 12'd2048;

    localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;

    // one bank entry
    typedef struct packed {
        logic               mark;
        logic [SRC_W-1:0]   src;
        logic [RANGE_W-1:0] rng;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result beat
    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic [SRC_W-1:0]   src;
        logic               last;
    } result_t;

    // pixel as it travels down the pipeline
    typedef struct packed {
        logic [RANGE_W-1:0] rv;
        logic [SRC_W-1:0]   sv;
        logic               last;
        logic [COL_W-1:0]   col;
        logic               wb;
    } item_t;

    // pixel with its resolved target position
    typedef struct packed {
        item_t            it;
        logic             hit;
        logic             has_t;
        logic [COL_W-1:0] p;
    } stg_t;

endpackage

### rtl/range_driven_row_shift_align_unit.sv
// range driven row shift align: two bank rams, read-modify-write pipeline, output queue
// path: an accepted beat runs through x1, x2, x3, st0, st1, st2 and the output queue to m_valid
// pacing: s_ready drops after each accepted beat and while no queue credit is left; a pixel
//   needs two read and two write slots on the one read and one write port of its bank ram
// reset: sync active low; afterwards a clearing pass zeroes both banks, one entry
//   of each per cycle over all ROW_LEN (2048) entries, s_ready low; config writes still taken
module range_driven_row_shift_align_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [rdsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rdsa_pkg::CFG_W-1:0]           cfg_wdata,
    // input pixels
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rdsa_pkg::RANGE_W-1:0]         s_range_value,
    input  logic [rdsa_pkg::SRC_W-1:0]           s_source_value,
    input  logic                                 s_row_end,
    // aligned pixels
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rdsa_pkg::RANGE_W-1:0]         m_aligned_range,
    output logic [rdsa_pkg::SRC_W-1:0]           m_aligned_source,
    output logic                                 m_row_end_out
);

    // configuration registers
    logic signed [rdsa_pkg::CFG_W-1:0] scale_reg;
    logic signed [rdsa_pkg::CFG_W-1:0] offset_reg;
    logic [rdsa_pkg::RLEN_W-1:0]       row_length_reg;
    logic                              write_range_reg;
    logic                              write_source_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg        <= rdsa_pkg::SCALE_RST;
            offset_reg       <= rdsa_pkg::OFFSET_RST;
            row_length_reg   <= rdsa_pkg::RLEN_RST;
            write_range_reg  <= 1'b1;
            write_source_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rdsa_pkg::REG_SHIFT_SCALE:  scale_reg        <= $signed(cfg_wdata);
                rdsa_pkg::REG_SHIFT_OFFSET: offset_reg       <= $signed(cfg_wdata);
                rdsa_pkg::REG_ROW_LENGTH:   row_length_reg   <= cfg_wdata[rdsa_pkg::RLEN_W-1:0];
                rdsa_pkg::REG_WRITE_RANGE:  write_range_reg  <= cfg_wdata[0];
                rdsa_pkg::REG_WRITE_SOURCE: write_source_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // accept control, column and bank tracking, clearing pass
    logic                               clr_reg;
    logic [rdsa_pkg::COL_W-1:0]         clr_addr_reg;
    logic                               acc_last_reg;
    logic [rdsa_pkg::OUTQ_CNT_W-1:0]    credit_reg, credit_next;
    logic [rdsa_pkg::COL_W-1:0]         col_reg, col_next;
    logic                               bank_reg, bank_next;
    logic                               s_accept;
    logic                               m_pop;

    assign s_ready  = !clr_reg && !acc_last_reg &&
                      (credit_reg != rdsa_pkg::OUTQ_CNT_W'(rdsa_pkg::OUTQ_DEPTH));
    assign s_accept = s_valid && s_ready;
    assign m_pop    = m_valid && m_ready;

    always_comb begin
        col_next    = col_reg;
        bank_next   = bank_reg;
        credit_next = credit_reg;
        if (s_accept) begin
            if (s_row_end) begin
                col_next  = '0;
                bank_next = !bank_reg;
            end else begin
                col_next = (col_reg == rdsa_pkg::COL_W'(rdsa_pkg::ROW_LEN - 1)) ?
                           '0 : col_reg + 1'b1;
            end
        end
        if (s_accept && !m_pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (m_pop && !s_accept) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            acc_last_reg <= 1'b0;
            credit_reg   <= '0;
            col_reg      <= '0;
            bank_reg     <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == rdsa_pkg::COL_W'(rdsa_pkg::ROW_LEN - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            acc_last_reg <= s_accept;
            credit_reg   <= credit_next;
            col_reg      <= col_next;
            bank_reg     <= bank_next;
        end
    end

    // shift computation: multiply, add offset, round and bound
    logic                                x1_vld_reg, x2_vld_reg, x3_vld_reg;
    rdsa_pkg::item_t                     x1_reg, x2_reg, x3_reg;
    logic signed [rdsa_pkg::PROD_W-1:0]  prod_next, prod_reg;
    logic signed [rdsa_pkg::SUM_W-1:0]   sum_next, sum_reg;
    logic [rdsa_pkg::FRAC_W-1:0]         frac;
    logic                                rnd_up;
    logic [rdsa_pkg::RND_W-1:0]          shift_val;
    logic [rdsa_pkg::Y_W-1:0]            y_val;
    logic [rdsa_pkg::LEN_W-1:0]          len_val;
    rdsa_pkg::stg_t                      st0_next;

    assign prod_next = $signed({1'b0, x1_reg.rv}) * scale_reg;
    assign sum_next  = prod_reg + offset_reg;

    assign len_val = (32'(row_length_reg) > 32'(rdsa_pkg::ROW_LEN)) ?
                     rdsa_pkg::LEN_W'(rdsa_pkg::ROW_LEN) : rdsa_pkg::LEN_W'(row_length_reg);

    // round half to even on the q16 sum
    assign frac      = sum_reg[rdsa_pkg::FRAC_W-1:0];
    assign rnd_up    = (frac > rdsa_pkg::HALF_Q16) ||
                       ((frac == rdsa_pkg::HALF_Q16) && sum_reg[rdsa_pkg::FRAC_W]);
    assign shift_val = rdsa_pkg::RND_W'($signed(sum_reg[rdsa_pkg::SUM_W-1:rdsa_pkg::FRAC_W]))
                       + rdsa_pkg::RND_W'(rnd_up);
    assign y_val     = rdsa_pkg::Y_W'(x3_reg.col) - {shift_val[rdsa_pkg::RND_W-1], shift_val};

    always_comb begin
        st0_next.it    = x3_reg;
        st0_next.hit   = (x3_reg.rv != '0) && !y_val[rdsa_pkg::Y_W-1] &&
                         (y_val[rdsa_pkg::Y_W-2:0] < (rdsa_pkg::Y_W - 1)'(len_val));
        st0_next.has_t = (y_val != '0);
        st0_next.p     = y_val[rdsa_pkg::COL_W-1:0];
    end

    // memory pipeline: st0 reads target, st1 writes target and reads neighbor and drain,
    // st2 writes neighbor and clears the drained entry
    logic           st0_vld_reg, st1_vld_reg, st2_vld_reg;
    rdsa_pkg::stg_t st0_reg, st1_reg, st2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_vld_reg  <= 1'b0;
            x2_vld_reg  <= 1'b0;
            x3_vld_reg  <= 1'b0;
            st0_vld_reg <= 1'b0;
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
        end else begin
            x1_vld_reg  <= s_accept;
            x2_vld_reg  <= x1_vld_reg;
            x3_vld_reg  <= x2_vld_reg;
            st0_vld_reg <= x3_vld_reg;
            st1_vld_reg <= st0_vld_reg;
            st2_vld_reg <= st1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x1_reg.rv   <= s_range_value;
        x1_reg.sv   <= s_source_value;
        x1_reg.last <= s_row_end;
        x1_reg.col  <= col_reg;
        x1_reg.wb   <= bank_reg;
        x2_reg      <= x1_reg;
        prod_reg    <= prod_next;
        x3_reg      <= x2_reg;
        sum_reg     <= sum_next;
        st0_reg     <= st0_next;
        st1_reg     <= st0_reg;
        st2_reg     <= st1_reg;
    end

    // bank rams with same-cycle write forwarding
    logic                        ram_we    [2];
    logic [rdsa_pkg::COL_W-1:0]  ram_waddr [2];
    rdsa_pkg::entry_t            ram_wdata [2];
    logic [rdsa_pkg::COL_W-1:0]  ram_raddr [2];
    logic [rdsa_pkg::ENTRY_W-1:0] ram_q    [2];
    logic                        fwd_hit_reg  [2];
    rdsa_pkg::entry_t            fwd_data_reg [2];
    rdsa_pkg::entry_t            rdat      [2];
    rdsa_pkg::entry_t            p_old, p_new, t_old, t_new, drain;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        rdsa_ram #(
            .WIDTH (rdsa_pkg::ENTRY_W),
            .DEPTH (rdsa_pkg::ROW_LEN)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[b]),
            .waddr (ram_waddr[b]),
            .wdata (ram_wdata[b]),
            .raddr (ram_raddr[b]),
            .rdata (ram_q[b])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fwd_hit_reg[b] <= 1'b0;
            end else begin
                fwd_hit_reg[b] <= ram_we[b] && (ram_waddr[b] == ram_raddr[b]);
            end
            fwd_data_reg[b] <= ram_wdata[b];
        end

        assign rdat[b] = fwd_hit_reg[b] ? fwd_data_reg[b] : rdsa_pkg::entry_t'(ram_q[b]);
    end

    // target entry update
    assign p_old = rdat[st1_reg.it.wb];
    always_comb begin
        p_new.mark = 1'b1;
        p_new.rng  = write_range_reg  ? st1_reg.it.rv : p_old.rng;
        p_new.src  = write_source_reg ? st1_reg.it.sv : p_old.src;
    end

    // neighbor entry: fill if empty, floor average if not placed
    assign t_old = rdat[st2_reg.it.wb];
    assign drain = rdat[!st2_reg.it.wb];
    always_comb begin
        t_new = t_old;
        if (write_range_reg) begin
            if (t_old.rng == '0) begin
                t_new.rng = st2_reg.it.rv;
            end else if (!t_old.mark) begin
                t_new.rng = rdsa_pkg::RANGE_W'(((rdsa_pkg::RANGE_W + 1)'(t_old.rng) +
                            (rdsa_pkg::RANGE_W + 1)'(st2_reg.it.rv)) >> 1);
            end
        end
        if (write_source_reg) begin
            if (t_old.src == '0) begin
                t_new.src = st2_reg.it.sv;
            end else if (!t_old.mark) begin
                t_new.src = rdsa_pkg::SRC_W'(((rdsa_pkg::SRC_W + 1)'(t_old.src) +
                            (rdsa_pkg::SRC_W + 1)'(st2_reg.it.sv)) >> 1);
            end
        end
    end

    // port steering; at most one of st0/st1 reads and one of st1/st2 writes in a cycle
    always_comb begin
        logic bsel;
        for (int b = 0; b < 2; b++) begin
            bsel = 1'(b);
            ram_raddr[b] = st0_reg.p;
            if (st0_vld_reg && (st0_reg.it.wb == bsel)) begin
                ram_raddr[b] = st0_reg.p;
            end else if (st1_vld_reg) begin
                ram_raddr[b] = (st1_reg.it.wb == bsel) ? st1_reg.p - 1'b1 : st1_reg.it.col;
            end

            ram_we[b]    = 1'b0;
            ram_waddr[b] = clr_addr_reg;
            ram_wdata[b] = '0;
            if (clr_reg) begin
                ram_we[b] = 1'b1;
            end else if (st1_vld_reg && st1_reg.hit && (st1_reg.it.wb == bsel)) begin
                ram_we[b]    = 1'b1;
                ram_waddr[b] = st1_reg.p;
                ram_wdata[b] = p_new;
            end else if (st2_vld_reg) begin
                if (st2_reg.it.wb == bsel) begin
                    ram_we[b]    = st2_reg.hit && st2_reg.has_t;
                    ram_waddr[b] = st2_reg.p - 1'b1;
                    ram_wdata[b] = t_new;
                end else begin
                    // drained entry goes back to zero
                    ram_we[b]    = 1'b1;
                    ram_waddr[b] = st2_reg.it.col;
                end
            end
        end
    end

    // result beats
    rdsa_pkg::result_t push_data;
    rdsa_pkg::result_t q_data;

    always_comb begin
        push_data.rng  = drain.rng;
        push_data.src  = drain.src;
        push_data.last = st2_reg.it.last;
    end

    rdsa_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st2_vld_reg),
        .push_data (push_data),
        .pop       (m_pop),
        .q_valid   (m_valid),
        .q_data    (q_data)
    );

    assign m_aligned_range  = q_data.rng;
    assign m_aligned_source = q_data.src;
    assign m_row_end_out    = q_data.last;

endmodule

### rtl/rdsa_ram.sv
// generic simple dual port ram with registered read
module rdsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rdsa_outq.sv
// small output queue that decouples the memory pipeline from the result channel
module rdsa_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rdsa_pkg::result_t push_data,
    input  logic              pop,
    output logic              q_valid,
    output rdsa_pkg::result_t q_data
);

    rdsa_pkg::result_t                    q_reg [rdsa_pkg::OUTQ_DEPTH];
    logic [rdsa_pkg::OUTQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rdsa_pkg::OUTQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rdsa_pkg::OUTQ_CNT_W-1:0]      cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rdsa_pkg::OUTQ_PTR_W'(rdsa_pkg::OUTQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rdsa_pkg::OUTQ_PTR_W'(rdsa_pkg::OUTQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_data  = q_reg[rd_ptr_reg];

endmodule

### rtl/rdsa_chk.sv
// port level checks for the range driven row shift align unit, bound to the top level
module rdsa_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [rdsa_pkg::RANGE_W-1:0]   m_aligned_range,
    input logic [rdsa_pkg::SRC_W-1:0]     m_aligned_source,
    input logic                           m_row_end_out
);

    // beats accepted but not yet delivered
    logic [rdsa_pkg::OUTQ_CNT_W:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + (rdsa_pkg::OUTQ_CNT_W + 1)'(s_valid && s_ready)
                        - (rdsa_pkg::OUTQ_CNT_W + 1)'(m_valid && m_ready);
        end
    end

    // clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // no two input beats are accepted back to back
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beats accepted back to back");

    // no result without a matching input beat
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != '0))
        else $error("result beat without pending input");

    // outstanding beats never exceed the output queue
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= (rdsa_pkg::OUTQ_CNT_W + 1)'(rdsa_pkg::OUTQ_DEPTH))
        else $error("too many outstanding beats");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_aligned_range) &&
        $stable(m_aligned_source) && $stable(m_row_end_out)))
        else $error("stalled result beat changed");

endmodule

bind range_driven_row_shift_align_unit rdsa_chk u_rdsa_chk (.*);

### test/range_driven_row_shift_align_unit_test.sv
// testbench for the range driven row shift align unit: scoreboard with a behavioral row model
module range_driven_row_shift_align_unit_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [rdsa_pkg::RANGE_W-1:0] rv;
        logic [rdsa_pkg::SRC_W-1:0]   sv;
        logic                         last;
    } pixel_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rdsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rdsa_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [rdsa_pkg::RANGE_W-1:0]   s_range_value = '0;
    logic [rdsa_pkg::SRC_W-1:0]     s_source_value = '0;
    logic                           s_row_end = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [rdsa_pkg::RANGE_W-1:0]   m_aligned_range;
    logic [rdsa_pkg::SRC_W-1:0]     m_aligned_source;
    logic                           m_row_end_out;

    pixel_t            pixel_queue[$];
    rdsa_pkg::result_t aligned_queue[$];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                errors = 0;
    int                cycles = 0;

    // row model: two banks of range, companion and placed marks
    bit [rdsa_pkg::RANGE_W-1:0] range_store [0:2*rdsa_pkg::ROW_LEN-1];
    bit [rdsa_pkg::SRC_W-1:0]   source_store [0:2*rdsa_pkg::ROW_LEN-1];
    bit                         placed [0:2*rdsa_pkg::ROW_LEN-1];
    bit [rdsa_pkg::COL_W-1:0]   col_pos = '0;
    bit                         write_bank = 1'b0;
    longint                     scale_cfg = 65536;
    longint                     offset_cfg = 0;
    bit [rdsa_pkg::RLEN_W-1:0]  row_len_cfg = 12'd2048;
    bit                         wr_range_cfg = 1'b1;
    bit                         wr_source_cfg = 1'b1;

    range_driven_row_shift_align_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_range_value   (s_range_value),
        .s_source_value  (s_source_value),
        .s_row_end       (s_row_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_aligned_range (m_aligned_range),
        .m_aligned_source(m_aligned_source),
        .m_row_end_out   (m_row_end_out)
    );

    always #5 aclk = ~aclk;

    task automatic align_pixel(input logic [rdsa_pkg::RANGE_W-1:0] rv,
                               input logic [rdsa_pkg::SRC_W-1:0] sv, input logic last);
        logic [11:0]                  rd_idx, p, t;
        longint                       v, shift, y, lim;
        logic [rdsa_pkg::RANGE_W:0]   sum_r;
        logic [rdsa_pkg::SRC_W:0]     sum_s;
        rdsa_pkg::result_t            beat;
        rd_idx = {~write_bank, col_pos};
        beat.rng  = range_store[rd_idx];
        beat.src  = source_store[rd_idx];
        beat.last = last;
        aligned_queue = {aligned_queue, beat};
        range_store[rd_idx]  = '0;
        source_store[rd_idx] = '0;
        placed[rd_idx]       = 1'b0;
        if (rv != 0) begin
            v = longint'(rv) * scale_cfg + offset_cfg;
            shift = v >>> 16;
            // round half to even
            if (v[15:0] > rdsa_pkg::HALF_Q16 ||
                (v[15:0] == rdsa_pkg::HALF_Q16 && shift[0])) begin
                shift++;
            end
            y = longint'(col_pos) - shift;
            lim = (row_len_cfg > 12'd2048) ? 2048 : longint'(row_len_cfg);
            if (y >= 0 && y < lim) begin
                p = {write_bank, y[rdsa_pkg::COL_W-1:0]};
                placed[p] = 1'b1;
                if (wr_range_cfg) begin
                    range_store[p] = rv;
                end
                if (wr_source_cfg) begin
                    source_store[p] = sv;
                end
                if (y >= 1) begin
                    t = p - 12'd1;
                    if (wr_range_cfg) begin
                        if (range_store[t] == 0) begin
                            range_store[t] = rv;
                        end else if (!placed[t]) begin
                            sum_r = {1'b0, range_store[t]} + {1'b0, rv};
                            range_store[t] = sum_r[rdsa_pkg::RANGE_W:1];
                        end
                    end
                    if (wr_source_cfg) begin
                        if (source_store[t] == 0) begin
                            source_store[t] = sv;
                        end else if (!placed[t]) begin
                            sum_s = {1'b0, source_store[t]} + {1'b0, sv};
                            source_store[t] = sum_s[rdsa_pkg::SRC_W:1];
                        end
                    end
                end
            end
        end
        if (last) begin
            col_pos = '0;
            write_bank = ~write_bank;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        // keep the log short when something goes systematically wrong
        if (errors < 100) begin
            $display("mismatch at cycle %0d: %s", cycles, msg);
        end
        errors++;
    endtask

    task automatic push_pixel(input logic [rdsa_pkg::RANGE_W-1:0] rv,
                              input logic [rdsa_pkg::SRC_W-1:0] sv, input logic last);
        pixel_t px;
        px.rv = rv;
        px.sv = sv;
        px.last = last;
        pixel_queue = {pixel_queue, px};
    endtask

    function automatic logic [rdsa_pkg::RANGE_W-1:0] rand_range();
        return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535));
    endfunction

    task automatic write_reg(input rdsa_pkg::cfg_reg_t idx,
                             input logic [rdsa_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rdsa_pkg::REG_SHIFT_SCALE:  scale_cfg = longint'($signed(val));
            rdsa_pkg::REG_SHIFT_OFFSET: offset_cfg = longint'($signed(val));
            rdsa_pkg::REG_ROW_LENGTH:   row_len_cfg = val[rdsa_pkg::RLEN_W-1:0];
            rdsa_pkg::REG_WRITE_RANGE:  wr_range_cfg = val[0];
            rdsa_pkg::REG_WRITE_SOURCE: wr_source_cfg = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [rdsa_pkg::CFG_W-1:0] sc,
                              input logic [rdsa_pkg::CFG_W-1:0] ofs,
                              input logic [rdsa_pkg::RLEN_W-1:0] len,
                              input logic wr, input logic ws);
        write_reg(rdsa_pkg::REG_SHIFT_SCALE, sc);
        write_reg(rdsa_pkg::REG_SHIFT_OFFSET, ofs);
        write_reg(rdsa_pkg::REG_ROW_LENGTH, rdsa_pkg::CFG_W'(len));
        write_reg(rdsa_pkg::REG_WRITE_RANGE, rdsa_pkg::CFG_W'(wr));
        write_reg(rdsa_pkg::REG_WRITE_SOURCE, rdsa_pkg::CFG_W'(ws));
    endtask

    // checked at the falling edge so every update of the rising edge has settled
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_valid || aligned_queue.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                align_pixel(s_range_value, s_source_value, s_row_end);
            end
            if (!(s_valid && !s_ready)) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pixel_queue.pop_front();
                    s_valid        <= 1'b1;
                    s_range_value  <= nxt.rv;
                    s_source_value <= nxt.sv;
                    s_row_end      <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        rdsa_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (aligned_queue.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = aligned_queue.pop_front();
                if (m_aligned_range !== want.rng || m_aligned_source !== want.src ||
                    m_row_end_out !== want.last) begin
                    report_mismatch($sformatf("got range %h source %h end %b, want %h %h %b",
                        m_aligned_range, m_aligned_source, m_row_end_out,
                        want.rng, want.src, want.last));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          k, n, row_len, ph;
        logic [31:0] scale_v, offset_v;
        logic [11:0] len_v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, unit scale: target is column minus range
        push_pixel(16'd1, 8'h00, 1'b0);
        push_pixel(16'd1, 8'hff, 1'b0);
        push_pixel(16'hffff, 8'h80, 1'b0);
        push_pixel(16'd0, 8'h55, 1'b0);
        push_pixel(16'd1, 8'h20, 1'b0);
        push_pixel(16'd3, 8'h40, 1'b0);
        push_pixel(16'd4, 8'h60, 1'b0);
        push_pixel(16'd2, 8'h7f, 1'b1);
        wait_idle();

        // fixed shift of 1.5 rounds to 2, length beyond the bank
        set_config(32'd0, 32'h0001_8000, 12'd4095, 1'b1, 1'b1);
        push_pixel(16'h8000, 8'h01, 1'b0);
        push_pixel(16'h0001, 8'h02, 1'b0);
        push_pixel(16'h1234, 8'h04, 1'b0);
        push_pixel(16'hffff, 8'h08, 1'b0);
        push_pixel(16'h7fff, 8'h10, 1'b1);
        wait_idle();

        // zero length and both stores disabled
        set_config(32'h8000_0000, 32'h7fff_ffff, 12'd0, 1'b0, 1'b0);
        push_pixel(16'd1, 8'haa, 1'b0);
        push_pixel(16'hffff, 8'hff, 1'b0);
        push_pixel(16'd2, 8'h01, 1'b1);
        wait_idle();

        set_config(32'h7fff_ffff, 32'h8000_0000, 12'd1, 1'b1, 1'b0);
        push_pixel(16'd1, 8'h11, 1'b0);
        push_pixel(16'd1, 8'h22, 1'b0);
        push_pixel(16'd2, 8'h33, 1'b1);
        wait_idle();

        // shift of -0.5 rounds to zero
        set_config(32'd0, 32'hffff_8000, 12'd2048, 1'b0, 1'b1);
        push_pixel(16'd5, 8'hc3, 1'b0);
        push_pixel(16'd6, 8'h3c, 1'b0);
        push_pixel(16'd7, 8'h99, 1'b1);
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case ($urandom_range(9))
                0: scale_v = $urandom;
                1: scale_v = -32'($urandom_range(1, 48));
                default: scale_v = 32'($urandom_range(0, 48));
            endcase
            case ($urandom_range(5))
                0: offset_v = 32'd0;
                1: offset_v = 32'($urandom_range(0, 6) * 65536) - 32'd196608 + 32'h8000;
                2: offset_v = $urandom;
                default: offset_v = 32'($urandom_range(0, 524288)) - 32'd262144;
            endcase
            case ($urandom_range(9))
                0: len_v = 12'd0;
                1: len_v = 12'd4095;
                2: len_v = 12'd2048;
                3: len_v = 12'($urandom_range(49, 4095));
                default: len_v = 12'($urandom_range(1, 48));
            endcase
            set_config(scale_v, offset_v, len_v, $urandom_range(3) != 0,
                       $urandom_range(3) != 0);
            k = 0;
            while (k < 175) begin
                if ($urandom_range(9) == 0) begin
                    // stray pixels with random row ends
                    repeat ($urandom_range(1, 6)) begin
                        push_pixel(16'($urandom_range(65535)), 8'($urandom_range(255)),
                                   1'($urandom_range(1)));
                        k++;
                    end
                end else begin
                    row_len = (len_v >= 1 && len_v <= 48) ? $urandom_range(1, len_v + 4)
                                                          : $urandom_range(1, 48);
                    for (n = 0; n < row_len; n++) begin
                        push_pixel(rand_range(), 8'($urandom_range(255)), n == row_len - 1);
                        k++;
                    end
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rdsa_pkg.sv
rtl/rdsa_ram.sv
rtl/rdsa_outq.sv
rtl/range_driven_row_shift_align_unit.sv
rtl/rdsa_chk.sv
test/range_driven_row_shift_align_unit_test.sv
